### rtl/mssd_pkg.sv
// ----------------------------------------------------------------------------
// mssd_pkg
// Types, event codes and the segment decoder shared by the display driver.
// ----------------------------------------------------------------------------
`default_nettype none

package mssd_pkg;

   // Event codes carried in the mode field.
   localparam logic [1:0] MODE_TICK    = 2'd0;
   localparam logic [1:0] MODE_CLEAR   = 2'd1;
   localparam logic [1:0] MODE_REFRESH = 2'd2;

   localparam logic [5:0]  SEC_LAST     = 6'd59;
   localparam logic [6:0]  MIN_LAST     = 7'd99;
   localparam logic [11:0] VOLT_FULL_MV = 12'd3300;
   localparam int unsigned DIGITS       = 4;
   localparam int unsigned FRAME_BITS   = 16;
   localparam int unsigned REFRESH_BITS = DIGITS * FRAME_BITS;

   // Decimal point positions.
   localparam logic [1:0] DP_VOLT = 2'd0;
   localparam logic [1:0] DP_TIME = 2'd1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] adc_sample;
      logic        show_voltage;
   } req_word_type;

   typedef struct packed {
      logic       serial_data;
      logic [1:0] frame_digit;
      logic       latch_after;
      logic       last;
   } rsp_word_type;

   // Four BCD digits, index 0 is the leftmost.
   typedef logic [DIGITS-1:0][3:0] digit_vec_type;

   typedef struct packed {
      digit_vec_type digits;
      logic [1:0]    dp_pos;
   } disp_type;

   // Common-anode segment byte, active low, point off.
   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] seg;
      unique case (digit)
         4'd0:    seg = 8'hC0;
         4'd1:    seg = 8'hF9;
         4'd2:    seg = 8'hA4;
         4'd3:    seg = 8'hB0;
         4'd4:    seg = 8'h99;
         4'd5:    seg = 8'h92;
         4'd6:    seg = 8'h82;
         4'd7:    seg = 8'hF8;
         4'd8:    seg = 8'h80;
         4'd9:    seg = 8'h90;
         default: seg = 8'hFF;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

### rtl/mssd_conv.sv
// ----------------------------------------------------------------------------
// mssd_conv
// Pipeline that turns a refresh word into four display digits: scales the
// converter sample to millivolts and splits it into decimal digits, or passes
// the time digits through.
// ----------------------------------------------------------------------------
`default_nettype none

module mssd_conv (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   input  wire  [15:0]              in_sample,
   input  wire                      in_volt,
   input  mssd_pkg::digit_vec_type  in_time,
   output logic                     in_full,
   input  wire                      out_ready,
   output logic                     out_valid,
   output mssd_pkg::disp_type       out_disp
);

   logic                    en;
   logic                    en1;

   logic                    s1_valid_ff;
   logic [15:0]             s1_sample_ff;
   logic                    s1_volt_ff;
   mssd_pkg::digit_vec_type s1_time_ff;

   logic                    s2_valid_ff;
   logic [27:0]             s2_prod_ff;
   logic                    s2_volt_ff;
   mssd_pkg::digit_vec_type s2_time_ff;

   logic                    s3_valid_ff;
   logic [11:0]             s3_mv_ff;
   logic                    s3_volt_ff;
   mssd_pkg::digit_vec_type s3_time_ff;

   logic                    s4_valid_ff;
   logic [1:0]              s4_thou_ff;
   logic [9:0]              s4_rem_ff;
   logic                    s4_volt_ff;
   mssd_pkg::digit_vec_type s4_time_ff;

   logic                    s5_valid_ff;
   logic [1:0]              s5_thou_ff;
   logic [3:0]              s5_hund_ff;
   logic [6:0]              s5_rem_ff;
   logic                    s5_volt_ff;
   mssd_pkg::digit_vec_type s5_time_ff;

   logic [27:0]             prod_in;
   logic [11:0]             q0;
   logic [16:0]             rsum;
   logic [11:0]             mv_in;
   logic [1:0]              thou_in;
   logic [9:0]              rem1_in;
   logic [15:0]             hund_prod;
   logic [3:0]              hund_in;
   logic [6:0]              rem2_in;
   logic [14:0]             tens_prod;
   logic [3:0]              tens;
   logic [6:0]              units_wide;

   // The whole pipe moves together; the first stage also fills into a hole.
   assign en      = !s5_valid_ff || out_ready;
   assign en1     = en || !s1_valid_ff;
   assign in_full = !en1;

   always_comb begin
      prod_in = {12'd0, s1_sample_ff} * {16'd0, mssd_pkg::VOLT_FULL_MV};

      // Division by 65535: the remainder estimate stays below twice the divisor.
      q0    = s2_prod_ff[27:16];
      rsum  = {1'b0, s2_prod_ff[15:0]} + {5'd0, q0};
      mv_in = q0 + {11'd0, (rsum >= 17'd65535)};

      if (s3_mv_ff >= 12'd3000) begin
         thou_in = 2'd3;
         rem1_in = 10'(s3_mv_ff - 12'd3000);
      end else if (s3_mv_ff >= 12'd2000) begin
         thou_in = 2'd2;
         rem1_in = 10'(s3_mv_ff - 12'd2000);
      end else if (s3_mv_ff >= 12'd1000) begin
         thou_in = 2'd1;
         rem1_in = 10'(s3_mv_ff - 12'd1000);
      end else begin
         thou_in = 2'd0;
         rem1_in = s3_mv_ff[9:0];
      end

      // x*41>>12 equals x/100 for x below 1000.
      hund_prod = {6'd0, s4_rem_ff} * 16'd41;
      hund_in   = hund_prod[15:12];
      rem2_in   = 7'(s4_rem_ff - 10'(hund_in) * 10'd100);

      // x*205>>11 equals x/10 for x below 1024.
      tens_prod  = {8'd0, s5_rem_ff} * 15'd205;
      tens       = tens_prod[14:11];
      units_wide = s5_rem_ff - 7'(tens) * 7'd10;

      if (s5_volt_ff) begin
         out_disp.digits[0] = {2'd0, s5_thou_ff};
         out_disp.digits[1] = s5_hund_ff;
         out_disp.digits[2] = tens;
         out_disp.digits[3] = units_wide[3:0];
         out_disp.dp_pos    = mssd_pkg::DP_VOLT;
      end else begin
         out_disp.digits    = s5_time_ff;
         out_disp.dp_pos    = mssd_pkg::DP_TIME;
      end
   end

   assign out_valid = s5_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_valid_ff <= in_valid;
         end
         if (en) begin
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
            s4_valid_ff <= s3_valid_ff;
            s5_valid_ff <= s4_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_sample_ff <= in_sample;
         s1_volt_ff   <= in_volt;
         s1_time_ff   <= in_time;
      end
      if (en) begin
         s2_prod_ff <= prod_in;
         s2_volt_ff <= s1_volt_ff;
         s2_time_ff <= s1_time_ff;

         s3_mv_ff   <= mv_in;
         s3_volt_ff <= s2_volt_ff;
         s3_time_ff <= s2_time_ff;

         s4_thou_ff <= thou_in;
         s4_rem_ff  <= rem1_in;
         s4_volt_ff <= s3_volt_ff;
         s4_time_ff <= s3_time_ff;

         s5_thou_ff <= s4_thou_ff;
         s5_hund_ff <= hund_in;
         s5_rem_ff  <= rem2_in;
         s5_volt_ff <= s4_volt_ff;
         s5_time_ff <= s4_time_ff;
      end
   end

endmodule

`default_nettype wire

### rtl/mssd_ser.sv
// ----------------------------------------------------------------------------
// mssd_ser
// Builds the four 16-bit frames of a refresh and shifts them out one bit per
// word, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module mssd_ser (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      load_valid,
   input  mssd_pkg::disp_type       load_disp,
   output logic                     load_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output mssd_pkg::rsp_word_type   rsp_word
);

   localparam int unsigned TOTAL = mssd_pkg::REFRESH_BITS;
   localparam int unsigned FB    = mssd_pkg::FRAME_BITS;

   logic                     busy_ff;
   logic [$clog2(TOTAL)-1:0] cnt_ff;
   logic [TOTAL-1:0]         frame_ff;
   logic [TOTAL-1:0]         frame_in;
   logic                     take;
   logic                     at_end;
   logic                     load;

   assign at_end     = (cnt_ff == ($clog2(TOTAL))'(TOTAL - 1));
   assign take       = busy_ff && !rsp_stall;
   assign load_ready = !busy_ff || (take && at_end);
   assign load       = load_valid && load_ready;

   always_comb begin
      logic [7:0] seg;
      frame_in = '0;
      for (int d = 0; d < mssd_pkg::DIGITS; d++) begin
         seg = mssd_pkg::seg_pattern(load_disp.digits[d]);
         if (load_disp.dp_pos == 2'(d)) begin
            seg[7] = 1'b0;
         end
         frame_in[TOTAL-1-FB*d -: FB] = {seg, 8'(1 << d)};
      end
   end

   assign rsp_valid            = busy_ff;
   assign rsp_word.serial_data = frame_ff[TOTAL-1];
   assign rsp_word.frame_digit = cnt_ff[$clog2(TOTAL)-1 -: 2];
   assign rsp_word.latch_after = &cnt_ff[$clog2(FB)-1:0];
   assign rsp_word.last        = at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (take) begin
         busy_ff <= !at_end;
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         frame_ff <= frame_in;
      end else if (take) begin
         frame_ff <= {frame_ff[TOTAL-2:0], 1'b0};
      end
   end

endmodule

`default_nettype wire

### rtl/minute_second_seven_segment_driver.sv
// A refresh word gives 64 output words, one per cycle while rsp_stall is low;
// its first bit appears once the word has gone through the conversion pipeline
// and into the shifter; a following refresh streams on with no gap.
// Tick and clear words update the counts as they are taken.
// Reset zeroes the seconds and minutes and empties the pipeline and shifter.
// ----------------------------------------------------------------------------
// minute_second_seven_segment_driver
// Minutes and seconds counter with a four-digit seven-segment display driver
// that streams segment and digit-enable frames to a shift-register chain.
// ----------------------------------------------------------------------------
`default_nettype none

module minute_second_seven_segment_driver (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  mssd_pkg::req_word_type  req_word,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output mssd_pkg::rsp_word_type  rsp_word
);

   logic [5:0]              sec_ff;
   logic [5:0]              sec_in;
   logic [6:0]              min_ff;
   logic [6:0]              min_in;
   logic                    req_take;
   logic                    refresh;
   logic [14:0]             min_prod;
   logic [14:0]             sec_prod;
   logic [3:0]              min_tens;
   logic [3:0]              sec_tens;
   logic [6:0]              min_units;
   logic [5:0]              sec_units;
   mssd_pkg::digit_vec_type time_digits;
   logic                    conv_full;
   logic                    conv_valid;
   mssd_pkg::disp_type      conv_disp;
   logic                    ser_ready;

   assign req_stall = conv_full;
   assign req_take  = req_valid && !req_stall;
   assign refresh   = req_take && (req_word.mode == mssd_pkg::MODE_REFRESH);

   always_comb begin
      sec_in = sec_ff;
      min_in = min_ff;
      if (req_take) begin
         case (req_word.mode)
            mssd_pkg::MODE_TICK: begin
               if (sec_ff >= mssd_pkg::SEC_LAST) begin
                  sec_in = '0;
                  min_in = (min_ff >= mssd_pkg::MIN_LAST) ? '0 : min_ff + 1'b1;
               end else begin
                  sec_in = sec_ff + 1'b1;
               end
            end
            mssd_pkg::MODE_CLEAR: begin
               sec_in = '0;
               min_in = '0;
            end
            default: begin
               sec_in = sec_ff;
               min_in = min_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sec_ff <= '0;
         min_ff <= '0;
      end else begin
         sec_ff <= sec_in;
         min_ff <= min_in;
      end
   end

   // Split the counts into tens and units: x*205>>11 is x/10 below 1024.
   always_comb begin
      min_prod  = {8'd0, min_ff} * 15'd205;
      sec_prod  = {9'd0, sec_ff} * 15'd205;
      min_tens  = min_prod[14:11];
      sec_tens  = sec_prod[14:11];
      min_units = min_ff - 7'(min_tens) * 7'd10;
      sec_units = sec_ff - 6'(sec_tens) * 6'd10;
      time_digits[0] = min_tens;
      time_digits[1] = min_units[3:0];
      time_digits[2] = sec_tens;
      time_digits[3] = sec_units[3:0];
   end

   mssd_conv u_conv (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (refresh),
      .in_sample (req_word.adc_sample),
      .in_volt   (req_word.show_voltage),
      .in_time   (time_digits),
      .in_full   (conv_full),
      .out_ready (ser_ready),
      .out_valid (conv_valid),
      .out_disp  (conv_disp)
   );

   mssd_ser u_ser (
      .clock      (clock),
      .reset      (reset),
      .load_valid (conv_valid),
      .load_disp  (conv_disp),
      .load_ready (ser_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

   // The counts never leave their display range.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (sec_ff <= mssd_pkg::SEC_LAST) && (min_ff <= mssd_pkg::MIN_LAST))
      else $error("time count out of range");

   // A refresh streams without gaps until its last bit.
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_word.last) |=> rsp_valid)
      else $error("gap inside a refresh stream");

   // A new refresh starts on the leftmost digit.
   a_new_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_word.last) |=>
      (!rsp_valid || (rsp_word.frame_digit == 2'd0 && !rsp_word.latch_after)))
      else $error("refresh does not start on digit zero");

endmodule

`default_nettype wire
